// ===== src/ssp_pkg.sv =====
// shared types, codes and constants of the speech synthesizer parameter interface
package ssp_pkg;

  // parameter frame layout
  localparam int unsigned NSLOTS   = 7;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned REP_W    = 5;
  localparam int unsigned REP_LSB  = 3;

  // configuration port
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // status bits
  localparam int unsigned ST_BUSY  = 7;
  localparam int unsigned ST_REQ   = 6;
  localparam int unsigned ST_EXT   = 5;
  localparam int unsigned ST_ERR   = 4;

  // status words written as a whole
  localparam logic [BYTE_W-1:0] STATUS_IDLE  = 8'h00;
  localparam logic [BYTE_W-1:0] STATUS_ERROR = 8'h10;
  localparam logic [BYTE_W-1:0] STATUS_EXT   = 8'he0;

  // command bytes
  localparam logic [BYTE_W-1:0] CMD_START_EXT = 8'hfe;
  localparam logic [BYTE_W-1:0] CMD_STOP      = 8'hff;
  localparam logic [BYTE_W-1:0] CMD_STOP_MAX  = 8'h04;

  // last slot of a frame
  localparam logic [SLOT_W-1:0] SLOT_LAST = 3'(NSLOTS - 1);

  // register indexes
  localparam logic REG_IRQ_ENABLE = 1'b0;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // input item opcodes
  typedef enum logic [2:0] {
    OP_DATA   = 3'd0,
    OP_MODE   = 3'd1,
    OP_CMD    = 3'd2,
    OP_STATUS = 3'd3,
    OP_TICK   = 3'd4
  } op_e;

endpackage

// ===== src/ssp_if.sv =====
// valid/ready channels for input items and result items
interface ssp_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    opcode;
  logic [ssp_pkg::BYTE_W-1:0]    bus_data;

  modport source (output valid, opcode, bus_data, input ready);
  modport sink (input valid, opcode, bus_data, output ready);
endinterface

interface ssp_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssp_pkg::BYTE_W-1:0]    status;
  logic                          irq;
  logic                          param_valid;
  logic [ssp_pkg::SLOT_W-1:0]    param_index;
  logic [ssp_pkg::BYTE_W-1:0]    param_value;
  logic                          last;

  modport source (output valid, status, irq, param_valid, param_index, param_value, last,
                  input ready);
  modport sink (input valid, status, irq, param_valid, param_index, param_value, last,
                output ready);
endinterface

// ===== src/speech_synth_param_interface.sv =====
// top level: bus decode, frame collection and frame hand-over of the speech synthesizer
// the first result of an accepted item is registered straight into the output register
// throughput: one item per cycle while out ready is high; a frame tick holds the output for
//   seven results, one slot per such cycle, and the next item is taken with the last of them
// reset (async, active low): status idle, buffer and counters zero, irq_enable set
// configuration is to be written through the apb port while no item is in flight; not enforced
module speech_synth_param_interface (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssp_pkg::PADDR_W-1:0]  paddr,
  input  logic [ssp_pkg::PDATA_W-1:0]  pwdata,
  output logic [ssp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  ssp_in_if.sink                       in_i,
  ssp_out_if.source                    out_o
);

  // configuration
  logic irq_enable_q;
  logic cfg_wr;

  // synthesizer state
  ssp_pkg::byte_t                  status_q, status_d;
  ssp_pkg::byte_t                  buf_q [ssp_pkg::NSLOTS];
  ssp_pkg::byte_t                  buf_d [ssp_pkg::NSLOTS];
  ssp_pkg::slot_t                  count_q, count_d;
  logic [ssp_pkg::REP_W-1:0]       rep_q, rep_d;
  logic                            ready_q, ready_d;
  logic                            ticks_q, ticks_d;

  // output register
  logic                            out_valid_q;
  ssp_pkg::byte_t                  out_status_q;
  logic                            out_irq_q;
  logic                            out_frame_q;
  ssp_pkg::slot_t                  out_idx_q;
  ssp_pkg::byte_t                  out_buf_q [ssp_pkg::NSLOTS];

  logic                            in_acc;
  logic                            out_last;
  logic                            out_acc;
  logic                            irq_d;
  logic                            emit_d;
  ssp_pkg::op_e                    op;
  ssp_pkg::slot_t                  count_inc;

  // apb register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == ssp_pkg::REG_IRQ_ENABLE) ?
                  ssp_pkg::PDATA_W'(irq_enable_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_enable_q <= 1'b1;
    end else if (cfg_wr && paddr[2] == ssp_pkg::REG_IRQ_ENABLE) begin
      irq_enable_q <= pwdata[0];
    end
  end

  // handshakes
  assign out_last = !out_frame_q || (out_idx_q == ssp_pkg::SLOT_LAST);
  assign out_acc  = out_valid_q && out_o.ready;
  assign in_i.ready = !out_valid_q || (out_o.ready && out_last);
  assign in_acc   = in_i.valid && in_i.ready;

  assign op        = ssp_pkg::op_e'(in_i.opcode);
  assign count_inc = count_q + 1'b1;

  // next state for one item
  always_comb begin
    status_d = status_q;
    buf_d    = buf_q;
    count_d  = count_q;
    rep_d    = rep_q;
    ready_d  = ready_q;
    ticks_d  = ticks_q;
    irq_d    = 1'b0;
    emit_d   = 1'b0;
    case (op)
      ssp_pkg::OP_DATA: begin
        if (status_q[ssp_pkg::ST_BUSY] && status_q[ssp_pkg::ST_REQ]) begin
          if (rep_q == '0 || count_q != '0) begin
            // normal frame byte
            if (count_q == '0) begin
              rep_d = in_i.bus_data[ssp_pkg::BYTE_W-1:ssp_pkg::REP_LSB];
            end
            buf_d[count_q] = in_i.bus_data;
            if (count_q == ssp_pkg::SLOT_LAST) begin
              status_d[ssp_pkg::ST_REQ] = 1'b0;
              count_d = '0;
              if (rep_d != '0) begin
                rep_d = rep_d - 1'b1;
              end
              ready_d = 1'b1;
            end else begin
              count_d = count_inc;
              irq_d   = 1'b1;
            end
          end else begin
            // repeat frame: slot 0 is kept, the slots between are cleared and only the last slot is new
            for (int i = 1; i < ssp_pkg::NSLOTS - 1; i++) begin
              buf_d[i] = '0;
            end
            buf_d[ssp_pkg::SLOT_LAST] = in_i.bus_data;
            status_d[ssp_pkg::ST_REQ] = 1'b0;
            count_d = '0;
            rep_d   = rep_q - 1'b1;
            ready_d = 1'b1;
          end
        end
      end
      ssp_pkg::OP_MODE: begin
        status_d = ssp_pkg::STATUS_IDLE;
      end
      ssp_pkg::OP_CMD: begin
        // every command stops speech first
        ticks_d  = 1'b0;
        count_d  = '0;
        rep_d    = '0;
        ready_d  = 1'b0;
        status_d[ssp_pkg::ST_BUSY] = 1'b0;
        if (in_i.bus_data == ssp_pkg::CMD_START_EXT) begin
          ticks_d  = 1'b1;
          status_d = ssp_pkg::STATUS_EXT;
          irq_d    = 1'b1;
        end else if (!(in_i.bus_data == ssp_pkg::CMD_STOP ||
                       in_i.bus_data <= ssp_pkg::CMD_STOP_MAX)) begin
          status_d = ssp_pkg::STATUS_ERROR;
        end
      end
      ssp_pkg::OP_TICK: begin
        if (ticks_q) begin
          if (status_q[ssp_pkg::ST_EXT] && ready_q &&
              buf_q[0][ssp_pkg::BYTE_W-1:ssp_pkg::REP_LSB] != '0) begin
            // hand the frame over
            ready_d = 1'b0;
            status_d[ssp_pkg::ST_REQ] = 1'b1;
            irq_d  = 1'b1;
            emit_d = 1'b1;
          end else begin
            ticks_d = 1'b0;
            count_d = '0;
            rep_d   = '0;
            ready_d = 1'b0;
            status_d[ssp_pkg::ST_BUSY] = 1'b0;
            if (status_q[ssp_pkg::ST_EXT] && !ready_q) begin
              status_d = ssp_pkg::STATUS_ERROR;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ssp_pkg::STATUS_IDLE;
      count_q  <= '0;
      rep_q    <= '0;
      ready_q  <= 1'b0;
      ticks_q  <= 1'b0;
      for (int i = 0; i < ssp_pkg::NSLOTS; i++) begin
        buf_q[i] <= '0;
      end
    end else if (in_acc) begin
      status_q <= status_d;
      count_q  <= count_d;
      rep_q    <= rep_d;
      ready_q  <= ready_d;
      ticks_q  <= ticks_d;
      buf_q    <= buf_d;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_frame_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
      out_idx_q   <= '0;
      out_frame_q <= emit_d;
    end else if (out_acc) begin
      if (out_last) begin
        out_valid_q <= 1'b0;
      end else begin
        out_idx_q <= out_idx_q + 1'b1;
      end
    end
  end

  // output payload, captured with every accepted item; frame bytes are snapshotted from the buffer
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_status_q <= status_d;
      out_irq_q    <= irq_d;
      out_buf_q    <= buf_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.last        = out_last;
  assign out_o.irq         = out_irq_q && out_last && irq_enable_q;
  assign out_o.param_valid = out_frame_q;
  assign out_o.param_index = out_frame_q ? out_idx_q : '0;
  assign out_o.param_value = out_frame_q ? out_buf_q[out_idx_q] : '0;

  // checks
  a_no_accept_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> !in_i.ready)
    else $error("item accepted while a frame is still being handed over");

  a_slot_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.param_valid && !out_o.last) |=>
    (out_o.valid && out_o.param_valid &&
     out_o.param_index == $past(out_o.param_index) + 3'd1))
    else $error("frame slots not handed over in order");

  a_irq_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.irq) |-> out_o.last)
    else $error("irq on a result that is not the last of its item");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 3'(ssp_pkg::NSLOTS))
    else $error("parameter count beyond frame length");

endmodule
